@@ rtl/core/bad_pkg.sv @@
// Package for the block average downscaler: channel and register widths,
// configuration register indexes, controller states and command/status structs.
// Depends on nothing; every other file of the block imports it.
package bad_pkg;

  // Pixel format: three 8-bit channels, blue in the lowest byte.
  localparam int CH_W   = 8;
  localparam int NUM_CH = 3;
  localparam int DATA_W = NUM_CH * CH_W;

  // Configuration register widths and port widths.
  localparam int SRC_WIDTH_W = 11;
  localparam int FACTOR_W    = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = SRC_WIDTH_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VFACTOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HFACTOR   = 2'd2;

  // Register values after reset.
  localparam logic [SRC_WIDTH_W-1:0] SRC_WIDTH_RST = 11'd640;
  localparam logic [FACTOR_W-1:0]    VFACTOR_RST   = 5'd2;
  localparam logic [FACTOR_W-1:0]    HFACTOR_RST   = 5'd2;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCUM,
    ST_DIVV,
    ST_DIVH
  } bad_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;     // write zero to the line store at the clear address
    logic take;       // input transaction accepted in this cycle
    logic accum;      // add the pixel to its column sum
    logic div_start;  // start the divider
    logic div_sel_h;  // divider works on the row sums by the horizontal factor
    logic row_acc;    // add the vertical average to the row sums
    logic grp_step;   // step the column position inside the horizontal group
    logic out_load;   // load the output register with a reduced pixel
    logic advance;    // step the row and column counters
  } bad_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;    // clearing pass is at its last entry
    logic last_row;    // current row closes its vertical group
    logic group_done;  // current column closes its horizontal group
    logic div_busy;    // divider is iterating
    logic out_busy;    // output register holds a result that is not taken
  } bad_status_t;

endpackage

@@ rtl/core/bad_div.sv @@
// Three-lane restoring divider, one quotient bit per cycle in each lane.
// Depends on bad_pkg for the lane count.
module bad_div
  import bad_pkg::*;
#(
  parameter int SUM_W = 12,
  parameter int DIV_W = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [NUM_CH-1:0][SUM_W-1:0]    dividend_i,
  input  logic [DIV_W-1:0]                divisor_i,
  output logic                            busy_o,
  output logic [NUM_CH-1:0][SUM_W-1:0]    quot_o
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic [NUM_CH-1:0][SUM_W-1:0]    acc_q, acc_d;
  logic [NUM_CH-1:0][DIV_W-1:0]    rem_q, rem_d;
  logic [DIV_W-1:0]                dvs_q;
  logic [NUM_CH-1:0][DIV_W:0]      trial;
  logic [NUM_CH-1:0]               ge;

  assign busy_o = (cnt_q != '0);
  assign quot_o = acc_q;

  // One restoring step per lane: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      trial[c] = {rem_q[c], acc_q[c][SUM_W-1]};
      ge[c]    = (trial[c] >= {1'b0, dvs_q});
      rem_d[c] = ge[c] ? DIV_W'(trial[c] - {1'b0, dvs_q}) : trial[c][DIV_W-1:0];
      acc_d[c] = {acc_q[c][SUM_W-2:0], ge[c]};
    end
  end

  // Iteration counter.
  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = CNT_W'(SUM_W);
    end else if (busy_o) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Dividend, quotient and remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_o) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

endmodule

@@ rtl/core/bad_datapath.sv @@
// Datapath of the block average downscaler: configuration registers, counters,
// column-sum line store, row sums, divider and output register.
// Depends on bad_pkg and instantiates bad_div.
module bad_datapath
  import bad_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_FACTOR = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration writes
  input  logic                   cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // input pixel
  input  logic [DATA_W-1:0]      in_data_i,
  input  logic                   in_frame_start_i,
  // output pixel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [DATA_W-1:0]      out_data_o,
  output logic                   out_row_end_o,
  // controller link
  input  bad_cmd_t               cmd_i,
  output bad_status_t            status_o
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_FACTOR);
  localparam int SUM_W  = $clog2(MAX_FACTOR * ((1 << CH_W) - 1) + 1);
  localparam int WMAX_W = $clog2(MAX_WIDTH + 1);
  localparam int WCMP_W = (WMAX_W > SRC_WIDTH_W) ? WMAX_W : SRC_WIDTH_W;
  localparam int WS_W   = WCMP_W + 1;
  localparam int FMAX_W = $clog2(MAX_FACTOR + 1);
  localparam int FCMP_W = (FMAX_W > FACTOR_W) ? FMAX_W : FACTOR_W;
  localparam int FS_W   = FCMP_W + 1;

  // Configuration registers.
  logic [SRC_WIDTH_W-1:0] src_width_q;
  logic [FACTOR_W-1:0]    vfactor_q;
  logic [FACTOR_W-1:0]    hfactor_q;

  // Effective settings after clamping.
  logic [WCMP_W-1:0] w_ext, width_eff;
  logic [FCMP_W-1:0] vf_ext, hf_ext, vf_eff, hf_eff;

  // Counters.
  logic [COL_W-1:0] col_q, col_eff, clr_addr_q;
  logic [ROW_W-1:0] row_q;
  logic [ROW_W-1:0] cig_q;

  // Pixel and sums.
  logic [NUM_CH-1:0][CH_W-1:0]  px_q;
  logic [NUM_CH-1:0][SUM_W-1:0] mem_q [MAX_WIDTH];
  logic [NUM_CH-1:0][SUM_W-1:0] rd_q;
  logic [NUM_CH-1:0][SUM_W-1:0] colsum_d;
  logic [NUM_CH-1:0][SUM_W-1:0] rowsum_q, rowsum_d;
  logic [NUM_CH-1:0][SUM_W-1:0] quot;
  logic [NUM_CH-1:0][SUM_W-1:0] dividend;
  logic [FCMP_W-1:0]            divisor;
  logic                         div_busy;

  // Position flags.
  logic last_col, last_row, group_done, row_end;

  // Output register.
  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;
  logic              out_row_end_q;

  // Configuration register writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q <= SRC_WIDTH_RST;
      vfactor_q   <= VFACTOR_RST;
      hfactor_q   <= HFACTOR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SRC_WIDTH: src_width_q <= cfg_data_i;
        CFG_VFACTOR:   vfactor_q   <= cfg_data_i[FACTOR_W-1:0];
        CFG_HFACTOR:   hfactor_q   <= cfg_data_i[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero setting acts as one; settings above the maxima saturate.
  always_comb begin
    w_ext  = WCMP_W'(src_width_q);
    vf_ext = FCMP_W'(vfactor_q);
    hf_ext = FCMP_W'(hfactor_q);
    if (w_ext == '0) begin
      width_eff = WCMP_W'(1);
    end else if (w_ext > WCMP_W'(MAX_WIDTH)) begin
      width_eff = WCMP_W'(MAX_WIDTH);
    end else begin
      width_eff = w_ext;
    end
    if (vf_ext == '0) begin
      vf_eff = FCMP_W'(1);
    end else if (vf_ext > FCMP_W'(MAX_FACTOR)) begin
      vf_eff = FCMP_W'(MAX_FACTOR);
    end else begin
      vf_eff = vf_ext;
    end
    if (hf_ext == '0) begin
      hf_eff = FCMP_W'(1);
    end else if (hf_ext > FCMP_W'(MAX_FACTOR)) begin
      hf_eff = FCMP_W'(MAX_FACTOR);
    end else begin
      hf_eff = hf_ext;
    end
  end

  // Position flags; a counter past its limit counts as being at the last position.
  assign last_col   = (WS_W'(col_q) + WS_W'(1)) >= WS_W'(width_eff);
  assign last_row   = (FS_W'(row_q) + FS_W'(1)) >= FS_W'(vf_eff);
  assign group_done = (FS_W'(cig_q) + FS_W'(1)) >= FS_W'(hf_eff);
  assign row_end    = last_col ||
                      ((WS_W'(col_q) + WS_W'(1) + WS_W'(hf_eff)) > WS_W'(width_eff));

  // The column addressed by an accepted pixel, after a frame start restart.
  assign col_eff = in_frame_start_i ? '0 : col_q;

  // Row, column and group counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cig_q <= '0;
    end else if (cmd_i.take) begin
      if (in_frame_start_i) begin
        col_q <= '0;
        row_q <= '0;
        cig_q <= '0;
      end
    end else begin
      if (cmd_i.grp_step) begin
        cig_q <= cig_q + ROW_W'(1);
      end
      if (cmd_i.out_load) begin
        cig_q <= '0;
      end
      if (cmd_i.advance) begin
        if (last_col) begin
          col_q <= '0;
          cig_q <= '0;
          row_q <= last_row ? '0 : row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
    end
  end

  // Clearing pass address after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_addr_q <= clr_addr_q + COL_W'(1);
    end
  end

  // Pixel capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      for (int c = 0; c < NUM_CH; c++) begin
        px_q[c] <= in_data_i[c*CH_W +: CH_W];
      end
    end
  end

  // New column sums: the first row of a group starts from zero.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      colsum_d[c] = ((row_q == '0) ? '0 : rd_q[c]) + SUM_W'(px_q[c]);
    end
  end

  // Line store of column sums, with a registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      mem_q[clr_addr_q] <= '0;
    end else if (cmd_i.accum) begin
      mem_q[col_q] <= colsum_d;
    end
    if (cmd_i.take) begin
      rd_q <= mem_q[col_eff];
    end
  end

  // Row sums of vertical averages: the first column of a group starts from zero.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      rowsum_d[c] = ((cig_q == '0) ? '0 : rowsum_q[c]) + quot[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_acc) begin
      rowsum_q <= rowsum_d;
    end
  end

  // Shared divider: column sums by the vertical factor, row sums by the horizontal one.
  assign dividend = cmd_i.div_sel_h ? rowsum_d : colsum_d;
  assign divisor  = cmd_i.div_sel_h ? hf_eff : vf_eff;

  bad_div #(
    .SUM_W (SUM_W),
    .DIV_W (FCMP_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // Output register; the controller loads it only when it is free or being emptied.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      for (int c = 0; c < NUM_CH; c++) begin
        out_data_q[c*CH_W +: CH_W] <= quot[c][CH_W-1:0];
      end
      out_row_end_q <= row_end;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_data_q;
  assign out_row_end_o = out_row_end_q;

  // Status to the controller.
  assign status_o.clr_last   = (clr_addr_q == COL_W'(MAX_WIDTH - 1));
  assign status_o.last_row   = last_row;
  assign status_o.group_done = group_done;
  assign status_o.div_busy   = div_busy;
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

endmodule

@@ rtl/core/bad_ctrl.sv @@
// Controller of the block average downscaler: sequences the clearing pass and
// the steps of each pixel. Depends on bad_pkg for states and command types.
module bad_ctrl
  import bad_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  bad_status_t status_i,
  output bad_cmd_t    cmd_o
);

  bad_state_e state_q, state_d;

  // State register; the line store is cleared first after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        if (status_i.last_row) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIVV;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_DIVV: begin
        if (!status_i.div_busy) begin
          cmd_o.row_acc = 1'b1;
          if (status_i.group_done) begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel_h = 1'b1;
            state_d         = ST_DIVH;
          end else begin
            cmd_o.grp_step = 1'b1;
            cmd_o.advance  = 1'b1;
            state_d        = ST_IDLE;
          end
        end
      end
      ST_DIVH: begin
        if (!status_i.div_busy && !status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          cmd_o.advance  = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/block_average_downscaler.sv @@
// Top level of the block average downscaler: joins controller and datapath.
// Depends on bad_pkg, bad_ctrl and bad_datapath.
//
// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata: blue, green, red; tuser: frame start
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata: blue, green, red; tlast: row end
// cfg       in         cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i
//
// A pixel on a row that does not close a vertical group passes through the accept and
// accumulate states. On the last row of a group the shared bit-serial divider forms the
// vertical average, and then the horizontal average when a reduced pixel is formed.
// After reset a clearing pass zeroes the line store; no pixel is accepted meanwhile,
// configuration writes are.
// A stalled output holds only the pixel that would load a new result; the next
// pixel is accepted while a result waits.
module block_average_downscaler
  import bad_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_FACTOR = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // source pixel stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [DATA_W-1:0]     s_axis_tdata,   // [7:0] in_blue, [15:8] in_green, [23:16] in_red
  input  logic                  s_axis_tuser,   // [0] frame_start
  // reduced pixel stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [DATA_W-1:0]     m_axis_tdata,   // [7:0] out_blue, [15:8] out_green, [23:16] out_red
  output logic                  m_axis_tlast,   // row_end
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  bad_cmd_t    cmd;
  bad_status_t status;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  bad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bad_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_data_i        (s_axis_tdata),
    .in_frame_start_i (s_axis_tuser),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_o       (m_axis_tdata),
    .out_row_end_o    (m_axis_tlast),
    .cmd_i            (cmd),
    .status_o         (status)
  );

  // A result is never loaded over one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("output register overwritten while stalled");

  // Starting the divider always leaves it busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> status.div_busy)
    else $error("divider did not start");

  // No pixel is accepted while the divider still works on the previous one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> !status.div_busy)
    else $error("pixel accepted during a division");

  // The clearing pass and pixel acceptance never overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> !s_axis_tready)
    else $error("pixel accepted during the clearing pass");

endmodule

@@ sim/bad_scale_checker.sv @@
`timescale 1ns / 1ps
// Checker for the block average downscaler: watches the pixel, result and
// configuration channels, predicts every reduced pixel and compares it.
// Depends on bad_pkg for widths and register indexes.
module bad_scale_checker
  import bad_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_FACTOR = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // source pixel channel
  input  logic                  pix_valid_i,
  input  logic                  pix_ready_i,
  input  logic [DATA_W-1:0]     pix_data_i,    // [7:0] blue, [15:8] green, [23:16] red
  input  logic                  pix_user_i,    // [0] frame start
  // reduced pixel channel
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  logic [DATA_W-1:0]     res_data_i,    // [7:0] blue, [15:8] green, [23:16] red
  input  logic                  res_last_i,    // row end
  // configuration channel
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // status towards the testbench top
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    results_o
);

  localparam int SUM_W = CH_W + $clog2(MAX_FACTOR);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int POS_W = $clog2(MAX_FACTOR);

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic            row_end;
  } reduced_px_t;

  // Shadow copies of the configuration registers.
  logic [SRC_WIDTH_W-1:0] width_reg;
  logic [FACTOR_W-1:0]    vfactor_reg;
  logic [FACTOR_W-1:0]    hfactor_reg;

  // Predicted state of the downscaler.
  logic [SUM_W-1:0] col_sums [MAX_WIDTH][NUM_CH];
  logic [SUM_W-1:0] row_acc  [NUM_CH];
  logic [POS_W-1:0] row_pos;
  logic [COL_W-1:0] col_pos;
  logic [POS_W-1:0] grp_pos;

  reduced_px_t expected_q[$];
  reduced_px_t oldest;
  int          mismatches;
  int          results_seen;

  // A zero register acts as one, oversized values saturate.
  function automatic int unsigned effective(int unsigned raw, int unsigned hi);
    if (raw == 0) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // Folds one source pixel into the column and row sums and queues the
  // reduced pixel that it completes, if any.
  task automatic downscale_pixel(input logic [DATA_W-1:0] data, input logic frame_start);
    int unsigned     width_e;
    int unsigned     vf_e;
    int unsigned     hf_e;
    int unsigned     col;
    int unsigned     avg;
    logic [CH_W-1:0] chan [NUM_CH];
    logic [CH_W-1:0] mean [NUM_CH];
    logic            last_row;
    logic            last_col;
    reduced_px_t     res;

    width_e = effective(32'(width_reg), MAX_WIDTH);
    vf_e    = effective(32'(vfactor_reg), MAX_FACTOR);
    hf_e    = effective(32'(hfactor_reg), MAX_FACTOR);
    for (int ch = 0; ch < NUM_CH; ch++) chan[ch] = data[ch*CH_W +: CH_W];

    if (frame_start) begin
      row_pos = '0;
      col_pos = '0;
      grp_pos = '0;
    end

    // A counter left beyond its limit by a register change counts as the last.
    col      = 32'(col_pos);
    last_col = (col + 1 >= width_e);
    if (col >= MAX_WIDTH) col = MAX_WIDTH - 1;
    last_row = (row_pos + 1 >= vf_e);

    for (int ch = 0; ch < NUM_CH; ch++)
      col_sums[col][ch] = ((row_pos == 0) ? '0 : col_sums[col][ch]) + SUM_W'(chan[ch]);

    // The vertical average joins the row sums on the last row of the group.
    if (last_row) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        avg         = col_sums[col][ch] / vf_e;
        row_acc[ch] = SUM_W'(((grp_pos == 0) ? '0 : row_acc[ch]) + avg);
      end
      if (grp_pos + 1 >= hf_e) begin
        for (int ch = 0; ch < NUM_CH; ch++) mean[ch] = CH_W'(row_acc[ch] / hf_e);
        res.blue    = mean[0];
        res.green   = mean[1];
        res.red     = mean[2];
        res.row_end = (col + 1 + hf_e > width_e) || last_col;
        expected_q.insert(expected_q.size(), res);
        grp_pos = '0;
      end else begin
        grp_pos = POS_W'(grp_pos + 1);
      end
    end

    // Trailing columns that do not fill a horizontal group are dropped here.
    if (last_col) begin
      col_pos = '0;
      grp_pos = '0;
      row_pos = last_row ? '0 : POS_W'(row_pos + 1);
    end else begin
      col_pos = COL_W'(col + 1);
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Every transaction is taken at the clock edge at which it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg   = SRC_WIDTH_RST;
      vfactor_reg = VFACTOR_RST;
      hfactor_reg = HFACTOR_RST;
      for (int i = 0; i < MAX_WIDTH; i++)
        for (int ch = 0; ch < NUM_CH; ch++) col_sums[i][ch] = '0;
      for (int ch = 0; ch < NUM_CH; ch++) row_acc[ch] = '0;
      row_pos      = '0;
      col_pos      = '0;
      grp_pos      = '0;
      expected_q.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SRC_WIDTH: width_reg   = cfg_data_i;
          CFG_VFACTOR:   vfactor_reg = cfg_data_i[FACTOR_W-1:0];
          CFG_HFACTOR:   hfactor_reg = cfg_data_i[FACTOR_W-1:0];
          default: ;
        endcase
      end

      if (pix_valid_i && pix_ready_i) downscale_pixel(pix_data_i, pix_user_i);

      if (res_valid_i && res_ready_i) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("reduced pixel with no expectation waiting: data %h, row end %b",
                 res_data_i, res_last_i);
          mismatches++;
        end else begin
          oldest = expected_q.pop_front();
          check_field("out_blue",  32'(oldest.blue),    32'(res_data_i[0*CH_W +: CH_W]));
          check_field("out_green", 32'(oldest.green),   32'(res_data_i[1*CH_W +: CH_W]));
          check_field("out_red",   32'(oldest.red),     32'(res_data_i[2*CH_W +: CH_W]));
          check_field("row_end",   32'(oldest.row_end), 32'(res_last_i));
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_q.size();
    results_o    <= results_seen;
  end

endmodule

@@ sim/tb_block_average_downscaler.sv @@
`timescale 1ns / 1ps
// Testbench top for the block average downscaler: clock, reset, pixel and
// configuration stimulus, output back-pressure and the final verdict.
// Depends on bad_pkg, block_average_downscaler and bad_scale_checker.
module tb_block_average_downscaler;
  import bad_pkg::*;

  localparam int          MAX_WIDTH      = 1024;
  localparam int          MAX_FACTOR     = 16;
  localparam int          RANDOM_ITEMS   = 100;
  localparam int          SETTLE_CYCLES  = 40;
  localparam int          HOLD_OFF       = 400;
  localparam int          HOLD_AFTER     = 40;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [DATA_W-1:0]     s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DATA_W-1:0]     m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int          fail_count;
  int          pending;
  int          results;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned cur_width = 32'(SRC_WIDTH_RST);
  int unsigned cur_vf = 32'(VFACTOR_RST);
  int unsigned cur_hf = 32'(HFACTOR_RST);
  bit          held_off = 1'b0;

  block_average_downscaler #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_FACTOR(MAX_FACTOR)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  bad_scale_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_FACTOR(MAX_FACTOR)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (s_axis_tvalid),
    .pix_ready_i (s_axis_tready),
    .pix_data_i  (s_axis_tdata),
    .pix_user_i  (s_axis_tuser),
    .res_valid_i (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_i  (m_axis_tdata),
    .res_last_i  (m_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Ends the run when no transaction of any channel has been accepted for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int unsigned effective(int unsigned raw, int unsigned hi);
    if (raw == 0) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // Random pixel with a fair share of fully dark and fully bright channels.
  function automatic logic [DATA_W-1:0] random_pixel();
    logic [DATA_W-1:0] px;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if ($urandom_range(0, 7) == 0)
        px[ch*CH_W +: CH_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else
        px[ch*CH_W +: CH_W] = CH_W'($urandom);
    end
    return px;
  endfunction

  // Leaves valid high so that back-to-back writes need no gap.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(value);
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic write_regs(input logic [2:0] mask, input int unsigned width,
                            input int unsigned vf, input int unsigned hf);
    if (mask[0]) begin
      write_reg(CFG_SRC_WIDTH, width);
      cur_width = width;
    end
    if (mask[1]) begin
      write_reg(CFG_VFACTOR, vf);
      cur_vf = vf;
    end
    if (mask[2]) begin
      write_reg(CFG_HFACTOR, hf);
      cur_hf = hf;
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Offers one pixel; the sender works in bursts with random gaps between them.
  task automatic push_pixel(input logic [DATA_W-1:0] px, input logic frame_start);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                               : $urandom_range(1, 8);
      gap = $urandom_range(0, 10);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= frame_start;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Waits until every expected result has come and the block has gone quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One stretch of traffic under a fresh, partly or unchanged setting.
  task automatic random_phase();
    int unsigned hf_raw;
    int unsigned vf_raw;
    int unsigned w_raw;
    int unsigned hf_e;
    int unsigned n;
    logic [2:0]  mask;

    hf_raw = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(0, 31);
    vf_raw = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(0, 31);
    hf_e   = effective(hf_raw, MAX_FACTOR);
    case ($urandom_range(0, 9))
      0: w_raw = 0;
      1: w_raw = $urandom_range(0, 1) ? MAX_WIDTH : $urandom_range(MAX_WIDTH + 1, 2047);
      2: w_raw = $urandom_range(1, 64);
      default: begin
        w_raw = hf_e * $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0) w_raw += $urandom_range(0, hf_e - 1);
      end
    endcase
    mask = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) : 3'b111;
    write_regs(mask, w_raw, vf_raw, hf_raw);

    // Whole vertical groups mostly; a cut-short frame leaves counters mid-row.
    n = effective(cur_width, MAX_WIDTH) * effective(cur_vf, MAX_FACTOR) *
        $urandom_range(1, 2);
    if (n > 240) n = $urandom_range(40, 240);
    if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
    for (int k = 0; k < n; k++)
      push_pixel(random_pixel(), (k == 0) ? ($urandom_range(0, 7) != 0)
                                          : ($urandom_range(0, 63) == 0));
    settle();
  endtask

  // Receiver: stalls on a pattern of its own, with one long hold-off.
  initial begin
    int unsigned len;
    int unsigned mode;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (!held_off && results >= HOLD_AFTER) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk_i);
      end else begin
        len  = $urandom_range(1, 32);
        mode = $urandom_range(0, 3);
        repeat (len) begin
          case (mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= 1'b0;
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned target;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero registers act as one: every pixel is its own reduced pixel.
    write_regs(3'b111, 0, 0, 0);
    push_pixel(24'h000000, 1'b1);
    push_pixel(24'hFFFFFF, 1'b0);
    push_pixel(24'h0F55AA, 1'b0);
    push_pixel(24'hF0AA55, 1'b0);
    settle();

    // Width not a multiple of the horizontal factor: the fifth column is dropped.
    write_regs(3'b111, 5, 2, 2);
    for (int i = 0; i < 10; i++)
      push_pixel({(i % 2) ? 8'hFF : 8'h00, 8'(255 - i * 7), 8'(i * 29)}, i == 0);
    settle();

    // Shrinking the width mid-row leaves the column counter past its limit.
    for (int i = 0; i < 3; i++) push_pixel(random_pixel(), 1'b0);
    settle();
    write_regs(3'b001, 2, 0, 0);
    for (int i = 0; i < 3; i++) push_pixel(random_pixel(), 1'b0);
    settle();

    // Oversized width saturates to the widest row, largest horizontal factor.
    write_regs(3'b111, 2047, 1, 31);
    for (int i = 0; i < MAX_WIDTH; i++) push_pixel(random_pixel(), i == 0);
    settle();

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) random_phase();
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
